### rtl/core/seua_pkg.sv
// ----------------------------------------------------------------------------
// seua_pkg
// Shared codes, widths and reset values for the shared/exclusive unit
// allocator.
// ----------------------------------------------------------------------------
package seua_pkg;

  typedef logic [3:0] shares_t;
  typedef logic [2:0] unit_idx_t;

  // request kinds
  localparam logic [1:0] KIND_SH_CLAIM = 2'd0;
  localparam logic [1:0] KIND_EX_CLAIM = 2'd1;
  localparam logic [1:0] KIND_SH_REL   = 2'd2;
  localparam logic [1:0] KIND_EX_REL   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_UNIT_COUNT = 2'd0;
  localparam logic [1:0] CFG_SHARE_CAP  = 2'd1;
  localparam logic [1:0] CFG_EXCL_UNITS = 2'd2;

  // reset values
  localparam logic [3:0] RESET_UNIT_COUNT = 4'd6;
  localparam shares_t    RESET_SHARES     = 4'd4;
  localparam logic [1:0] RESET_EXCL_UNITS = 2'd3;

  // largest exclusive claim
  localparam logic [1:0] MAX_PER_CLAIM = 2'd3;

endpackage

### rtl/core/seua_ram.sv
// ----------------------------------------------------------------------------
// seua_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module seua_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/shared_exclusive_unit_allocator.sv
// ----------------------------------------------------------------------------
// shared_exclusive_unit_allocator
// Share counters per unit in a RAM; claims scan from unit zero, shared
// releases read-modify-write one entry, exclusive ones reset to capacity.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ channel (valid/stall), one result word per
//   request leaves on the out_ channel. Configuration goes through cfg_we,
//   cfg_index and cfg_wdata, written by the user only while the block is
//   idle; the block does not enforce this. One request is worked at a
//   time; in_stall is high from acceptance until the output register is loaded.
//   Sequence per request kind, with k units per exclusive claim:
//     shared claim      pipelined scan from unit zero, one read a cycle
//     exclusive claim   scan, then one write a cycle to the k picked units
//     shared release    read, then modify and write back
//     exclusive release one RAM write a cycle to each of the k units
//   The single RAM port pair reads one counter and writes one per cycle.
//   Reset returns the registers to unit_count 6, share_capacity 4,
//   exclusive_units 3, and marks every counter as holding 4 shares through
//   per-entry valid bits; no clearing pass is needed.
//   A stalled result holds in the output register; the next request may be
//   accepted and worked meanwhile, and its result waits until the slot frees.
module shared_exclusive_unit_allocator #(
  parameter int MAX_UNITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_wdata,
  // requests
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic       in_held_valid,
  input  logic [2:0] in_unit_a,
  input  logic [2:0] in_unit_b,
  input  logic [2:0] in_unit_c,
  // results
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic [1:0] out_granted_count,
  output logic [2:0] out_grant_a,
  output logic [2:0] out_grant_b,
  output logic [2:0] out_grant_c
);

  localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int NW = AW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_XWR   = 3'd2;
  localparam logic [2:0] S_RDREL = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // configuration registers
  logic [3:0]        ucnt_r;
  seua_pkg::shares_t cap_r;
  logic [1:0]        xun_r;

  // request and sequencer state
  logic [2:0]          state_r, state_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [NW-1:0]       sc_r, sc_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]       rd_addr_r;
  logic                rd_vld_r;
  logic [1:0]          found_r, found_nxt;
  logic [1:0]          w_r, w_nxt;
  logic [AW-1:0]       tgt_r [3];
  logic [AW-1:0]       tgt_nxt [3];
  logic [2:0]          wmask_r, wmask_nxt;
  seua_pkg::shares_t   wval_r, wval_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic [1:0]          res_cnt_r, res_cnt_nxt;
  seua_pkg::unit_idx_t gr_r [3];
  seua_pkg::unit_idx_t gr_nxt [3];
  logic [MAX_UNITS-1:0] vld_r;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [1:0]          out_cnt_r, out_cnt_nxt;
  seua_pkg::unit_idx_t out_gr_r [3];
  seua_pkg::unit_idx_t out_gr_nxt [3];

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  seua_pkg::shares_t ram_wdata;
  logic [AW-1:0]     ram_raddr;
  seua_pkg::shares_t ram_rdata;

  logic [NW-1:0]     n_lim;
  logic [1:0]        k_lim;
  seua_pkg::shares_t cur_v;
  logic              issue;
  logic              accept;

  seua_ram #(
    .WIDTH (4),
    .DEPTH (MAX_UNITS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign n_lim = (32'(ucnt_r) > MAX_UNITS) ? NW'(MAX_UNITS) : NW'(ucnt_r);
  assign k_lim = (xun_r > seua_pkg::MAX_PER_CLAIM) ? seua_pkg::MAX_PER_CLAIM : xun_r;

  // an entry never written still holds its reset share count
  assign cur_v  = rd_vld_r ? ram_rdata : seua_pkg::RESET_SHARES;
  assign issue  = (sc_r < n_lim);
  assign accept = in_valid && (state_r == S_IDLE);

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_granted_count = out_cnt_r;
  assign out_grant_a       = out_gr_r[0];
  assign out_grant_b       = out_gr_r[1];
  assign out_grant_c       = out_gr_r[2];

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    sc_nxt      = sc_r;
    rd_pend_nxt = rd_pend_r;
    found_nxt   = found_r;
    w_nxt       = w_r;
    tgt_nxt     = tgt_r;
    wmask_nxt   = wmask_r;
    wval_nxt    = wval_r;
    res_ok_nxt  = res_ok_r;
    res_cnt_nxt = res_cnt_r;
    gr_nxt      = gr_r;
    ram_we      = 1'b0;
    ram_waddr   = rd_addr_r;
    ram_wdata   = cur_v;
    ram_raddr   = '0;

    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_cnt_nxt   = out_cnt_r;
    out_gr_nxt    = out_gr_r;

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = AW'(in_unit_a);
        if (accept) begin
          kind_nxt    = in_kind;
          sc_nxt      = '0;
          rd_pend_nxt = 1'b0;
          found_nxt   = '0;
          w_nxt       = '0;
          res_ok_nxt  = 1'b0;
          res_cnt_nxt = '0;
          gr_nxt[0]   = '0;
          gr_nxt[1]   = '0;
          gr_nxt[2]   = '0;
          if (k_lim == '0) begin
            state_nxt = S_DONE;
          end else begin
            unique case (in_kind) inside
              seua_pkg::KIND_SH_CLAIM,
              seua_pkg::KIND_EX_CLAIM: begin
                state_nxt = S_SCAN;
              end
              seua_pkg::KIND_SH_REL: begin
                res_ok_nxt = in_held_valid;
                if (in_held_valid && (int'(in_unit_a) < int'(n_lim))) begin
                  state_nxt = S_RDREL;
                end else begin
                  state_nxt = S_DONE;
                end
              end
              seua_pkg::KIND_EX_REL: begin
                res_ok_nxt   = in_held_valid;
                tgt_nxt[0]   = AW'(in_unit_a);
                tgt_nxt[1]   = AW'(in_unit_b);
                tgt_nxt[2]   = AW'(in_unit_c);
                wmask_nxt[0] = (int'(in_unit_a) < int'(n_lim));
                wmask_nxt[1] = (int'(in_unit_b) < int'(n_lim));
                wmask_nxt[2] = (int'(in_unit_c) < int'(n_lim));
                wval_nxt     = cap_r;
                state_nxt    = in_held_valid ? S_XWR : S_DONE;
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end

      S_SCAN: begin
        // one read issued per cycle, data checked the cycle after
        ram_raddr   = sc_r[AW-1:0];
        rd_pend_nxt = issue;
        if (issue) begin
          sc_nxt = sc_r + NW'(1);
        end
        if (kind_r == seua_pkg::KIND_SH_CLAIM) begin
          if (rd_pend_r && (cur_v != '0)) begin
            ram_we      = 1'b1;
            ram_waddr   = rd_addr_r;
            ram_wdata   = cur_v - 4'd1;
            res_ok_nxt  = 1'b1;
            res_cnt_nxt = 2'd1;
            gr_nxt[0]   = 3'(rd_addr_r);
            state_nxt   = S_DONE;
          end else if (!rd_pend_r && !issue) begin
            state_nxt = S_DONE;
          end
        end else begin
          if (rd_pend_r && (cur_v == cap_r)) begin
            tgt_nxt[found_r] = rd_addr_r;
            gr_nxt[found_r]  = 3'(rd_addr_r);
            found_nxt        = found_r + 2'd1;
            if ((found_r + 2'd1) == k_lim) begin
              wmask_nxt   = 3'b111;
              wval_nxt    = '0;
              w_nxt       = '0;
              res_ok_nxt  = 1'b1;
              res_cnt_nxt = k_lim;
              state_nxt   = S_XWR;
            end
          end else if (!rd_pend_r && !issue) begin
            // too few free units: drop partial picks
            gr_nxt[0] = '0;
            gr_nxt[1] = '0;
            gr_nxt[2] = '0;
            state_nxt = S_DONE;
          end
        end
      end

      S_XWR: begin
        ram_we    = wmask_r[w_r];
        ram_waddr = tgt_r[w_r];
        ram_wdata = wval_r;
        if (w_r == (k_lim - 2'd1)) begin
          state_nxt = S_DONE;
        end else begin
          w_nxt = w_r + 2'd1;
        end
      end

      S_RDREL: begin
        if (cur_v < cap_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_r;
          ram_wdata = cur_v + 4'd1;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold the result until the output slot frees
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_cnt_nxt   = res_cnt_r;
          out_gr_nxt    = gr_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucnt_r      <= seua_pkg::RESET_UNIT_COUNT;
      cap_r       <= seua_pkg::RESET_SHARES;
      xun_r       <= seua_pkg::RESET_EXCL_UNITS;
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          seua_pkg::CFG_UNIT_COUNT: ucnt_r <= cfg_wdata;
          seua_pkg::CFG_SHARE_CAP:  cap_r  <= cfg_wdata;
          seua_pkg::CFG_EXCL_UNITS: xun_r  <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    sc_r      <= sc_nxt;
    rd_addr_r <= ram_raddr;
    rd_vld_r  <= vld_r[ram_raddr];
    found_r   <= found_nxt;
    w_r       <= w_nxt;
    tgt_r     <= tgt_nxt;
    wmask_r   <= wmask_nxt;
    wval_r    <= wval_nxt;
    res_ok_r  <= res_ok_nxt;
    res_cnt_r <= res_cnt_nxt;
    gr_r      <= gr_nxt;
    out_ok_r  <= out_ok_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_gr_r  <= out_gr_nxt;
  end

endmodule
